/* rtl/core/incdf_pkg.sv */
// shared types, constants and coefficient tables of the inverse normal cdf core
package incdf_pkg;

  localparam int RESULT_W             = 48;
  localparam int RESULT_FRAC_BITS_DEF = 32;
  localparam int CFG_W                = 32;
  localparam int T_FRAC_BITS          = 26;
  localparam int LOG_FRAC_BITS        = 30;
  localparam int HORNER_STEPS         = 9;

  localparam logic OP_ERFINV   = 1'b0;
  localparam logic OP_QUANTILE = 1'b1;

  localparam logic REG_MEAN    = 1'b0;
  localparam logic REG_STD_DEV = 1'b1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_DOMAIN = 2'd1;
  localparam logic [1:0] STATUS_SAT    = 2'd2;

  localparam logic [31:0] MEAN_RESET    = 32'd0;
  localparam logic [31:0] STD_DEV_RESET = 32'd65536;

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;
  localparam logic [30:0] T_SPLIT   = 31'd411041792;
  localparam logic [62:0] MAG_CAP   = 63'h4000000000000000;

  typedef struct packed {
    logic               op;
    logic               dom;
    logic signed [31:0] x;
  } ctx_t;

  typedef struct packed {
    ctx_t               ctx;
    logic               tail;
    logic [30:0]        tm;
    logic signed [63:0] p;
  } hstate_t;

  // Q8.56 coefficients, tail set led by a zero so both sets take nine steps
  localparam logic signed [63:0] COEF_TAIL [0:9] = '{
    64'sd0,
    64'sh14deb44 <<< 0,
    64'sh1f7c9ae <<< 6,
    64'sh147e512 <<< 12,
    64'sh1dca7de <<< 16,
    64'sh19cab92 <<< 20,
    64'sh18cc0de <<< 23,
    64'sh13ca920 <<< 24,
    -(64'sh10eff66 <<< 30),
    64'sh1ae16a4 <<< 31
  };

  localparam logic signed [63:0] COEF_BODY [0:9] = '{
    64'sh175c000 <<< 4,
    64'sh133b402 <<< 9,
    64'sh1499232 <<< 12,
    64'sh1e52cd2 <<< 8,
    -(64'sh1d70bd0 <<< 17),
    -(64'sh135be90 <<< 19),
    64'sh12f6400 <<< 23,
    64'sh17a1e50 <<< 25,
    -(64'sh1db2aee <<< 29),
    64'sh1c5bf88 <<< 31
  };

endpackage

/* rtl/core/incdf_umul.sv */
// three-stage unsigned multiplier with round-half-up shift and magnitude cap
module incdf_umul #(
  parameter int AW   = 32,
  parameter int BW   = 32,
  parameter int SH_A = 26,
  parameter int SH_B = 26,
  parameter int SW   = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic          sel_i,
  input  logic [AW-1:0] a_i,
  input  logic [BW-1:0] b_i,
  input  logic [SW-1:0] sb_i,
  output logic          valid_o,
  output logic [62:0]   mag_o,
  output logic [SW-1:0] sb_o
);

  localparam logic [127:0] RND_A = 128'd1 << (SH_A - 1);
  localparam logic [127:0] RND_B = 128'd1 << (SH_B - 1);

  logic [63:0]  a_w, b_w;
  logic [63:0]  pp00_q, pp01_q, pp10_q, pp11_q;
  logic [63:0]  lo_q, hi_q;
  logic [64:0]  mid_q;
  logic         sel1_q, sel2_q;
  logic [SW-1:0] sb1_q, sb2_q, sb3_q;
  logic         v1_q, v2_q, v3_q;
  logic [127:0] sum_w, shr_w;
  logic [62:0]  mag_d, mag_q;

  assign a_w = 64'(a_i);
  assign b_w = 64'(b_i);

  always_comb begin
    sum_w = {hi_q, lo_q} + (128'(mid_q) << 32) + (sel2_q ? RND_B : RND_A);
    shr_w = sel2_q ? (sum_w >> SH_B) : (sum_w >> SH_A);
    mag_d = (shr_w > 128'(incdf_pkg::MAG_CAP)) ? incdf_pkg::MAG_CAP : shr_w[62:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp00_q <= 64'(a_w[31:0]) * 64'(b_w[31:0]);
      pp01_q <= 64'(a_w[31:0]) * 64'(b_w[63:32]);
      pp10_q <= 64'(a_w[63:32]) * 64'(b_w[31:0]);
      pp11_q <= 64'(a_w[63:32]) * 64'(b_w[63:32]);
      sel1_q <= sel_i;
      sb1_q  <= sb_i;
      lo_q   <= pp00_q;
      hi_q   <= pp11_q;
      mid_q  <= 65'(pp01_q) + 65'(pp10_q);
      sel2_q <= sel1_q;
      sb2_q  <= sb1_q;
      mag_q  <= mag_d;
      sb3_q  <= sb2_q;
    end
  end

  assign valid_o = v3_q;
  assign mag_o   = mag_q;
  assign sb_o    = sb3_q;

endmodule

/* rtl/core/incdf_log.sv */
// pipelined natural log of 1 - x*x, giving |t| in q5.26
module incdf_log (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [62:0]        u_i,
  input  incdf_pkg::ctx_t    ctx_i,
  output logic               valid_o,
  output logic [30:0]        tm_o,
  output incdf_pkg::ctx_t    ctx_o
);

  localparam int NS  = incdf_pkg::LOG_FRAC_BITS;
  localparam int CW  = $bits(incdf_pkg::ctx_t);

  logic [5:0]      lead_w;
  logic [5:0]      shamt_w;
  logic [31:0]     m_s   [0:NS];
  logic [NS-1:0]   f_s   [0:NS];
  logic [5:0]      e_s   [0:NS];
  incdf_pkg::ctx_t c_s   [0:NS];
  logic            v_s   [0:NS];
  logic [34:0]     n_d, n_q;
  logic [5:0]      ipart_w;
  incdf_pkg::ctx_t cn_q;
  logic            vn_q;
  logic [62:0]     mag_w;
  logic [CW-1:0]   sb_w;

  // leading one and normalisation
  always_comb begin
    lead_w = '0;
    for (int i = 0; i < 63; i++) begin
      if (u_i[i]) begin
        lead_w = 6'(i);
      end
    end
    shamt_w = lead_w - 6'd31;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_s[0] <= 1'b0;
    end else if (en_i) begin
      v_s[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_s[0] <= 32'(u_i >> shamt_w);
      f_s[0] <= '0;
      e_s[0] <= lead_w;
      c_s[0] <= ctx_i;
    end
  end

  // one fraction bit per stage by squaring the mantissa
  for (genvar j = 0; j < NS; j++) begin : g_sq
    logic [63:0] sq_w;
    logic [32:0] m2_w;
    always_comb begin
      sq_w = 64'(m_s[j]) * 64'(m_s[j]);
      m2_w = sq_w[63:31];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_s[j+1] <= 1'b0;
      end else if (en_i) begin
        v_s[j+1] <= v_s[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_s[j+1] <= m2_w[32] ? m2_w[32:1] : m2_w[31:0];
        f_s[j+1] <= f_s[j] | (NS'(m2_w[32]) << (NS - 1 - j));
        e_s[j+1] <= e_s[j];
        c_s[j+1] <= c_s[j];
      end
    end
  end

  always_comb begin
    ipart_w = 6'd62 - e_s[NS];
    n_d     = {ipart_w[4:0], 30'd0} - 35'(f_s[NS]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (en_i) begin
      vn_q <= v_s[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q  <= n_d;
      cn_q <= c_s[NS];
    end
  end

  // scale log2 by ln 2
  incdf_umul #(
    .AW  (35),
    .BW  (32),
    .SH_A(36),
    .SH_B(36),
    .SW  (CW)
  ) u_ln2 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(vn_q),
    .sel_i  (1'b0),
    .a_i    (n_q),
    .b_i    (incdf_pkg::LN2_Q32),
    .sb_i   (cn_q),
    .valid_o(valid_o),
    .mag_o  (mag_w),
    .sb_o   (sb_w)
  );

  assign tm_o  = mag_w[30:0];
  assign ctx_o = incdf_pkg::ctx_t'(sb_w);

endmodule

/* rtl/core/incdf_step.sv */
// one horner step p = round(p*t) + c, five register stages
module incdf_step #(
  parameter int STEP = 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  incdf_pkg::hstate_t hs_i,
  output logic               valid_o,
  output incdf_pkg::hstate_t hs_o
);

  localparam int HSW = $bits(incdf_pkg::hstate_t);
  localparam logic signed [63:0] C_TAIL = incdf_pkg::COEF_TAIL[STEP];
  localparam logic signed [63:0] C_BODY = incdf_pkg::COEF_BODY[STEP];

  logic signed [63:0] pneg_w;
  logic [62:0]        pa_q;
  logic               neg_q;
  logic               v0_q;
  incdf_pkg::hstate_t hs0_q;
  logic               vm_w;
  logic [62:0]        mag_w;
  logic [HSW:0]       sb_w;
  incdf_pkg::hstate_t hs_u;
  logic signed [63:0] prod_s;
  incdf_pkg::hstate_t hs_d, hs_q;
  logic               v_q;

  assign pneg_w = -hs_i.p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v_q  <= 1'b0;
    end else if (en_i) begin
      v0_q <= valid_i;
      v_q  <= vm_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q  <= hs_i.p[63] ? pneg_w[62:0] : hs_i.p[62:0];
      neg_q <= hs_i.p[63] ^ (hs_i.tm != '0);
      hs0_q <= hs_i;
      hs_q  <= hs_d;
    end
  end

  incdf_umul #(
    .AW  (63),
    .BW  (31),
    .SH_A(incdf_pkg::T_FRAC_BITS),
    .SH_B(incdf_pkg::T_FRAC_BITS),
    .SW  (HSW + 1)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_i),
    .valid_i(v0_q),
    .sel_i  (1'b0),
    .a_i    (pa_q),
    .b_i    (hs0_q.tm),
    .sb_i   ({neg_q, hs0_q}),
    .valid_o(vm_w),
    .mag_o  (mag_w),
    .sb_o   (sb_w)
  );

  always_comb begin
    hs_u   = incdf_pkg::hstate_t'(sb_w[HSW-1:0]);
    prod_s = $signed({1'b0, mag_w});
    if (sb_w[HSW]) begin
      prod_s = -prod_s;
    end
    hs_d   = hs_u;
    hs_d.p = prod_s + (hs_u.tail ? C_TAIL : C_BODY);
  end

  assign valid_o = v_q;
  assign hs_o    = hs_q;

endmodule

/* rtl/core/incdf_outq.sv */
// two-entry result queue between the pipeline and the output channel
module incdf_outq #(
  parameter int W = 50
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [0:1];
  logic         wptr_q, rptr_q;
  logic [1:0]   cnt_q, cnt_d;
  logic         pop_w;

  assign pop_w   = valid_o && ready_i;
  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign data_o  = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_w) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_w && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_w) begin
        rptr_q <= ~rptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

/* rtl/core/inverse_normal_cdf_top.sv */
// inverse error function and normal quantile core, top level
//
//   channel  signals                                   dir  beat
//   in       in_valid_i in_ready_o operation_i argument_i in  valid & ready
//   out      out_valid_o out_ready_i result_o status_o    out valid & ready
//   cfg      cfg_we_i cfg_index_i cfg_wdata_i              in   we, no wait
//
// one beat per cycle sustained while the output queue has room
// the pipeline includes the 30-stage log squaring chain and nine 5-stage horner steps
// all stages advance together while the two-entry output queue has room
// a result waiting on the output does not stop input until the queue fills
// reset clears valid bits, queue and registers (mean 0, std_dev 1.0)
module inverse_normal_cdf_top #(
  parameter int RESULT_FRAC_BITS = incdf_pkg::RESULT_FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic signed [31:0]            argument_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [incdf_pkg::RESULT_W-1:0] result_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_index_i,
  input  logic [incdf_pkg::CFG_W-1:0]   cfg_wdata_i
);

  localparam int RW   = incdf_pkg::RESULT_W;
  localparam int NSTP = incdf_pkg::HORNER_STEPS;
  localparam int SH_E = 87 - RESULT_FRAC_BITS;
  localparam int SH_Q = 102 - RESULT_FRAC_BITS;
  localparam int MSH  = RESULT_FRAC_BITS - 16;

  logic en_w, full_w;

  // configuration
  logic [31:0] mean_q, std_q;
  logic [62:0] k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= incdf_pkg::MEAN_RESET;
      std_q  <= incdf_pkg::STD_DEV_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        incdf_pkg::REG_MEAN:    mean_q <= cfg_wdata_i;
        incdf_pkg::REG_STD_DEV: std_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= 63'(std_q) * 63'(incdf_pkg::SQRT2_Q30);
  end

  assign en_w       = ~full_w;
  assign in_ready_o = en_w;

  // input stage, square, complement
  incdf_pkg::ctx_t ca_d, ca_q, cb_q, cc_q;
  logic            va_q, vb_q, vc_q;
  logic [63:0]     sq_w;
  logic [61:0]     sq_q;
  logic [62:0]     u_q;

  always_comb begin
    ca_d.op = operation_i;
    if (operation_i == incdf_pkg::OP_QUANTILE) begin
      ca_d.dom = argument_i[31] || (argument_i == 32'sd0);
      ca_d.x   = {~argument_i[30], argument_i[29:0], 1'b0};
    end else begin
      ca_d.dom = argument_i == 32'sh80000000;
      ca_d.x   = argument_i;
    end
  end

  assign sq_w = 64'(ca_q.x * ca_q.x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_w) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      ca_q <= ca_d;
      sq_q <= sq_w[61:0];
      cb_q <= ca_q;
      u_q  <= (63'd1 << 62) - 63'(sq_q);
      cc_q <= cb_q;
    end
  end

  // t = ln(1 - x*x)
  logic            vl_w;
  logic [30:0]     tm_w;
  incdf_pkg::ctx_t cl_w;

  incdf_log u_log (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_w),
    .valid_i(vc_q),
    .u_i    (u_q),
    .ctx_i  (cc_q),
    .valid_o(vl_w),
    .tm_o   (tm_w),
    .ctx_o  (cl_w)
  );

  // horner chain
  incdf_pkg::hstate_t hs_c [0:NSTP];
  logic               v_c  [0:NSTP];

  always_comb begin
    hs_c[0].ctx  = cl_w;
    hs_c[0].tm   = tm_w;
    hs_c[0].tail = tm_w > incdf_pkg::T_SPLIT;
    hs_c[0].p    = hs_c[0].tail ? incdf_pkg::COEF_TAIL[0] : incdf_pkg::COEF_BODY[0];
  end

  assign v_c[0] = vl_w;

  for (genvar s = 1; s <= NSTP; s++) begin : g_step
    incdf_step #(
      .STEP(s)
    ) u_step (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en_w),
      .valid_i(v_c[s-1]),
      .hs_i   (hs_c[s-1]),
      .valid_o(v_c[s]),
      .hs_o   (hs_c[s])
    );
  end

  // x * p, then scale for the quantile
  logic signed [31:0] xneg_w;
  logic signed [63:0] pneg_w;
  logic [30:0]        xa_q;
  logic [62:0]        pa_q;
  logic               nf_q, opf_q, domf_q, vf_q;

  assign xneg_w = -hs_c[NSTP].ctx.x;
  assign pneg_w = -hs_c[NSTP].p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (en_w) begin
      vf_q <= v_c[NSTP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_w) begin
      xa_q   <= hs_c[NSTP].ctx.x[31] ? xneg_w[30:0] : hs_c[NSTP].ctx.x[30:0];
      pa_q   <= hs_c[NSTP].p[63] ? pneg_w[62:0] : hs_c[NSTP].p[62:0];
      nf_q   <= hs_c[NSTP].ctx.x[31] ^ hs_c[NSTP].p[63];
      opf_q  <= hs_c[NSTP].ctx.op;
      domf_q <= hs_c[NSTP].ctx.dom;
    end
  end

  logic        v1_w, v2_w;
  logic [62:0] m1_w, m2_w;
  logic [2:0]  sb1_w;
  logic [65:0] sb2_w;

  incdf_umul #(
    .AW  (31),
    .BW  (63),
    .SH_A(SH_E),
    .SH_B(31),
    .SW  (3)
  ) u_mul_xp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_w),
    .valid_i(vf_q),
    .sel_i  (opf_q),
    .a_i    (xa_q),
    .b_i    (pa_q),
    .sb_i   ({nf_q, opf_q, domf_q}),
    .valid_o(v1_w),
    .mag_o  (m1_w),
    .sb_o   (sb1_w)
  );

  incdf_umul #(
    .AW  (63),
    .BW  (63),
    .SH_A(SH_Q),
    .SH_B(SH_Q),
    .SW  (66)
  ) u_mul_k (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en_w),
    .valid_i(v1_w),
    .sel_i  (1'b0),
    .a_i    (m1_w),
    .b_i    (k_q),
    .sb_i   ({sb1_w, m1_w}),
    .valid_o(v2_w),
    .mag_o  (m2_w),
    .sb_o   (sb2_w)
  );

  // sign, mean, domain check, saturation
  logic               neg_w, op_w, dom_w;
  logic signed [63:0] r0_w, r1_w, r_w, mean_sh_w;
  logic signed [RW-1:0] res_w;
  logic [1:0]         st_w;

  always_comb begin
    neg_w     = sb2_w[65];
    op_w      = sb2_w[64];
    dom_w     = sb2_w[63];
    mean_sh_w = $signed({{32{mean_q[31]}}, mean_q}) <<< MSH;
    r0_w      = $signed({1'b0, sb2_w[62:0]});
    r1_w      = $signed({1'b0, m2_w});
    if (neg_w) begin
      r0_w = -r0_w;
      r1_w = -r1_w;
    end
    r1_w = r1_w + mean_sh_w;
    r_w  = (op_w == incdf_pkg::OP_QUANTILE) ? r1_w : r0_w;
    res_w = r_w[RW-1:0];
    st_w  = incdf_pkg::STATUS_OK;
    if (dom_w) begin
      res_w = '0;
      st_w  = incdf_pkg::STATUS_DOMAIN;
    end else if (!r_w[63] && (r_w[62:RW-1] != '0)) begin
      res_w = {1'b0, {(RW-1){1'b1}}};
      st_w  = incdf_pkg::STATUS_SAT;
    end else if (r_w[63] && (r_w[62:RW-1] != '1)) begin
      res_w = {1'b1, {(RW-1){1'b0}}};
      st_w  = incdf_pkg::STATUS_SAT;
    end
  end

  logic [RW+1:0] q_out_w;

  incdf_outq #(
    .W(RW + 2)
  ) u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (en_w && v2_w),
    .data_i ({st_w, res_w}),
    .full_o (full_w),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .data_o (q_out_w)
  );

  assign result_o = q_out_w[RW-1:0];
  assign status_o = q_out_w[RW+1:RW];

endmodule
